FILE: sv/bbpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpe_pkg: shared types, constants and helpers
// Fixed-point formats and the narrow division step used by the bicubic
// Bezier patch evaluator.
// ----------------------------------------------------------------------------
package bbpe_pkg;

  // Parameter in Q1.15; one is 2^15.
  typedef logic [15:0] frac_t;
  // Bernstein weight in Q.20, never above 2^20.
  typedef logic [20:0] weight_t;
  // Division count and partial remainder.
  typedef logic [7:0]  div_t;

  localparam logic [15:0] FRAC_ONE     = 16'h8000;
  localparam int          WEIGHT_SHIFT = 25;   // Q.45 down to Q.20
  localparam int          ROW_SHIFT    = 12;   // keep 8 guard bits
  localparam int          OUT_SHIFT    = 28;   // weight bits plus guard bits
  localparam logic [7:0]  DIV_RESET    = 8'd7;

  // Configuration register indexes.
  localparam logic [0:0]  REG_DIVISION_COUNT = 1'b0;

  // Request kinds.
  localparam logic        REQ_WRITE = 1'b0;
  localparam logic        REQ_EVAL  = 1'b1;

  // Eight steps of restoring division: returns {remainder, quotient bits}.
  function automatic logic [15:0] div_step8(input div_t rem, input logic [7:0] bits,
                                            input div_t den);
    logic [8:0] t;
    div_t       r;
    logic [7:0] q;
    r = rem;
    q = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, den}) begin
        t    = t - {1'b0, den};
        q[i] = 1'b1;
      end
      r = t[7:0];
    end
    return {r, q};
  endfunction

endpackage

FILE: sv/bbpe_frac_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpe_frac_div: three-stage pipelined fraction divider
// Divides a 24-bit numerator by an 8-bit divisor, eight quotient bits per
// stage, and returns the low 16 quotient bits.
// ----------------------------------------------------------------------------
module bbpe_frac_div (
  input  logic             clk,
  input  logic             en,
  input  logic [23:0]      num,
  input  bbpe_pkg::div_t   den,
  output bbpe_pkg::frac_t  quo
);
  import bbpe_pkg::*;

  logic [15:0] st1_res, st2_res, st3_res;
  div_t        rem1, rem2, den1, den2;
  logic [15:0] num1;
  logic [7:0]  num2, q2, q3;

  assign st1_res = div_step8('0, num[23:16], den);
  assign st2_res = div_step8(rem1, num1[15:8], den1);
  assign st3_res = div_step8(rem2, num2, den2);

  // The top eight quotient bits are always zero since the fraction is at most one.
  always_ff @(posedge clk) begin
    if (en) begin
      rem1 <= st1_res[15:8];
      num1 <= num[15:0];
      den1 <= den;
      rem2 <= st2_res[15:8];
      q2   <= st2_res[7:0];
      num2 <= num1[7:0];
      den2 <= den1;
      q3   <= st3_res[7:0];
    end
  end

  // Hold q2 in step with the third stage.
  logic [7:0] q2_d;
  always_ff @(posedge clk) begin
    if (en) begin
      q2_d <= q2;
    end
  end

  assign quo = {q2_d, q3};

endmodule

FILE: sv/bicubic_bezier_patch_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_eval: bicubic Bezier patch vertex evaluator
// Holds a 4x4 grid of control points and evaluates one patch vertex per
// evaluate beat from two step indices.
// ----------------------------------------------------------------------------
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  req      | req_valid/req_stall, req_type..inner_step | in
//  vtx      | vtx_valid/vtx_stall, vertex_x..fractions  | out
//  apb      | psel/penable/pwrite/paddr/pwdata/prdata   | config
//
// One beat is accepted per cycle while the output is not stalled; a vertex
// passes through the ten-stage pipeline (division, weights, row and column
// sums). A control point write takes effect in stage six, behind any
// evaluate already in flight. Reset is synchronous and clears valid bits
// and sets the division count to seven. A stall on the output freezes the
// whole pipeline and holds the input stalled.
// ----------------------------------------------------------------------------
module bicubic_bezier_patch_eval #(
  parameter int STEP_BITS  = 8,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // Request channel
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic                         req_type,
  input  logic [1:0]                   grid_row,
  input  logic [1:0]                   grid_col,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic [STEP_BITS-1:0]         outer_step,
  input  logic [STEP_BITS-1:0]         inner_step,
  // Vertex channel
  output logic                         vtx_valid,
  input  logic                         vtx_stall,
  output logic signed [COORD_BITS-1:0] vertex_x,
  output logic signed [COORD_BITS-1:0] vertex_y,
  output logic signed [COORD_BITS-1:0] vertex_z,
  output bbpe_pkg::frac_t              outer_fraction,
  output bbpe_pkg::frac_t              inner_fraction,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bbpe_pkg::*;

  localparam int CW = (STEP_BITS > 8) ? STEP_BITS : 8;
  localparam int PW = COORD_BITS + 22;     // weight times coordinate
  localparam int RW = PW + 2;              // sum of four
  localparam int TW = RW - ROW_SHIFT;      // intermediate point
  localparam int MW = TW + 22;             // weight times intermediate point
  localparam int AW = MW + 2;              // sum of four
  localparam int XW = AW - OUT_SHIFT;      // vertex before saturation

  typedef struct packed {
    logic [3:0]                   idx;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] pz;
  } wr_t;

  // Pipeline advance: everything moves unless a finished vertex is held.
  logic en;
  assign en        = !(vtx_valid && vtx_stall);
  assign req_stall = !en;

  // Configuration register.
  div_t division_count;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      division_count <= DIV_RESET;
    end else if (psel && penable && pwrite && paddr == {REG_DIVISION_COUNT, 2'b00}) begin
      division_count <= pwdata[7:0];
    end
  end
  assign prdata = (paddr == {REG_DIVISION_COUNT, 2'b00}) ? {24'd0, division_count} : 32'd0;

  // Valid and kind bits for stages one to nine.
  logic vld  [1:9];
  logic kind [1:9];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 9; i++) begin
        vld[i] <= 1'b0;
      end
      vtx_valid <= 1'b0;
    end else if (en) begin
      vld[1] <= req_valid;
      for (int i = 2; i <= 9; i++) begin
        vld[i] <= vld[i-1];
      end
      vtx_valid <= vld[9] && kind[9] == REQ_EVAL;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      kind[1] <= req_type;
      for (int i = 2; i <= 9; i++) begin
        kind[i] <= kind[i-1];
      end
    end
  end

  // Stage zero: saturate the steps and form the numerators s*2^15 + d/2.
  div_t           d_eff;
  logic [CW-1:0]  su_w, sv_w;
  div_t           su, sv;
  logic [23:0]    num_u, num_v;
  always_comb begin
    d_eff = (division_count == '0) ? 8'd1 : division_count;
    su_w  = (CW'(outer_step) > CW'(d_eff)) ? CW'(d_eff) : CW'(outer_step);
    sv_w  = (CW'(inner_step) > CW'(d_eff)) ? CW'(d_eff) : CW'(inner_step);
    su    = su_w[7:0];
    sv    = sv_w[7:0];
    num_u = {1'b0, su, 15'd0} + {17'd0, d_eff[7:1]};
    num_v = {1'b0, sv, 15'd0} + {17'd0, d_eff[7:1]};
  end

  // Stages one to three: the fractions.
  frac_t fu3, fv3;
  bbpe_frac_div u_div_u (.clk(clk), .en(en), .num(num_u), .den(d_eff), .quo(fu3));
  bbpe_frac_div u_div_v (.clk(clk), .en(en), .num(num_v), .den(d_eff), .quo(fv3));

  // Write payload rides along until stage six.
  wr_t wr_p [1:6];
  always_ff @(posedge clk) begin
    if (en) begin
      wr_p[1] <= '{idx: {grid_row, grid_col}, px: point_x, py: point_y, pz: point_z};
      for (int i = 2; i <= 6; i++) begin
        wr_p[i] <= wr_p[i-1];
      end
    end
  end

  // Fractions ride along to the output.
  frac_t fu_p [4:9];
  frac_t fv_p [4:9];
  always_ff @(posedge clk) begin
    if (en) begin
      fu_p[4] <= fu3;
      fv_p[4] <= fv3;
      for (int i = 5; i <= 9; i++) begin
        fu_p[i] <= fu_p[i-1];
        fv_p[i] <= fv_p[i-1];
      end
    end
  end

  // Stage four: squares and cross product for both parameters (index 0 = u).
  frac_t       f4 [2];
  frac_t       g4 [2];
  logic [31:0] ff4 [2];
  logic [31:0] gg4 [2];
  logic [31:0] fg4 [2];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        f4[k]  <= (k == 0) ? fu3 : fv3;
        g4[k]  <= FRAC_ONE - ((k == 0) ? fu3 : fv3);
        ff4[k] <= 32'((k == 0) ? fu3 : fv3) * 32'((k == 0) ? fu3 : fv3);
        gg4[k] <= 32'(FRAC_ONE - ((k == 0) ? fu3 : fv3))
                  * 32'(FRAC_ONE - ((k == 0) ? fu3 : fv3));
        fg4[k] <= 32'((k == 0) ? fu3 : fv3) * 32'(FRAC_ONE - ((k == 0) ? fu3 : fv3));
      end
    end
  end

  // Stage five: cubic products f^3, f^2 g, f g^2, g^3.
  logic [46:0] p5 [2][4];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        p5[k][0] <= 47'(ff4[k]) * 47'(f4[k]);
        p5[k][1] <= 47'(ff4[k]) * 47'(g4[k]);
        p5[k][2] <= 47'(fg4[k]) * 47'(g4[k]);
        p5[k][3] <= 47'(gg4[k]) * 47'(g4[k]);
      end
    end
  end

  // Stage six: scale the middle terms by three and round to Q.20.
  weight_t w6 [2][4];
  logic [47:0] wt_full [2][4];
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int c = 0; c < 4; c++) begin
        if (c == 1 || c == 2) begin
          wt_full[k][c] = ({1'b0, p5[k][c]} + {p5[k][c], 1'b0}
                           + (48'd1 << (WEIGHT_SHIFT - 1))) >> WEIGHT_SHIFT;
        end else begin
          wt_full[k][c] = ({1'b0, p5[k][c]} + (48'd1 << (WEIGHT_SHIFT - 1)))
                          >> WEIGHT_SHIFT;
        end
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        for (int c = 0; c < 4; c++) begin
          w6[k][c] <= wt_full[k][c][20:0];
        end
      end
    end
  end

  // Control grid, written as a write beat leaves stage six.
  logic signed [COORD_BITS-1:0] grid [16][3];
  always_ff @(posedge clk) begin
    if (en && vld[6] && kind[6] == REQ_WRITE) begin
      grid[wr_p[6].idx][0] <= wr_p[6].px;
      grid[wr_p[6].idx][1] <= wr_p[6].py;
      grid[wr_p[6].idx][2] <= wr_p[6].pz;
    end
  end

  // Stage seven: row products with the outer weights.
  logic signed [PW-1:0] prod7 [3][4][4];
  weight_t wv7 [4];
  weight_t wv8 [4];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            prod7[a][r][c] <= $signed({1'b0, w6[0][c]}) * grid[r*4 + c][a];
          end
        end
      end
      wv7 <= w6[1];
      wv8 <= wv7;
    end
  end

  // Stage eight: row sums rounded to intermediate points.
  logic signed [RW-1:0] row_sum [3][4];
  logic signed [TW-1:0] t8 [3][4];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int r = 0; r < 4; r++) begin
        row_sum[a][r] = RW'(prod7[a][r][0]) + RW'(prod7[a][r][1]) + RW'(prod7[a][r][2])
                        + RW'(prod7[a][r][3]) + (RW'(1) <<< (ROW_SHIFT - 1));
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int r = 0; r < 4; r++) begin
          t8[a][r] <= TW'(row_sum[a][r] >>> ROW_SHIFT);
        end
      end
    end
  end

  // Stage nine: intermediate points times the inner weights.
  logic signed [MW-1:0] m9 [3][4];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int r = 0; r < 4; r++) begin
          m9[a][r] <= $signed({1'b0, wv8[r]}) * t8[a][r];
        end
      end
    end
  end

  // Stage ten: final sum, rounding and saturation into the output register.
  localparam logic signed [XW-1:0] CMAX = XW'((64'sd1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [XW-1:0] CMIN = -CMAX - XW'(1);
  logic signed [AW-1:0]         acc [3];
  logic signed [XW-1:0]         res [3];
  logic signed [COORD_BITS-1:0] sat [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc[a] = AW'(m9[a][0]) + AW'(m9[a][1]) + AW'(m9[a][2]) + AW'(m9[a][3])
               + (AW'(1) <<< (OUT_SHIFT - 1));
      res[a] = XW'(acc[a] >>> OUT_SHIFT);
      if (res[a] > CMAX) begin
        sat[a] = CMAX[COORD_BITS-1:0];
      end else if (res[a] < CMIN) begin
        sat[a] = CMIN[COORD_BITS-1:0];
      end else begin
        sat[a] = res[a][COORD_BITS-1:0];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      vertex_x       <= sat[0];
      vertex_y       <= sat[1];
      vertex_z       <= sat[2];
      outer_fraction <= fu_p[9];
      inner_fraction <= fv_p[9];
    end
  end

endmodule
